// File: rtl/core/swvm_pkg.sv
// Shared types and constants for the sliding-window vector mean block.
`default_nettype none

package swvm_pkg;

	// Window depth; ring slot arithmetic wraps as a power of two
	localparam int WINDOW_MAX = 16;
	localparam int COORD_BITS = 32;
	localparam int AXES       = 3;

	localparam int SLOT_BITS  = $clog2(WINDOW_MAX);
	localparam int CNT_BITS   = $clog2(WINDOW_MAX + 1);
	localparam int SUM_BITS   = COORD_BITS + SLOT_BITS;

	// Divider retires two quotient bits per cycle
	localparam int DIV_STEPS  = (SUM_BITS + 1) / 2;
	localparam int DIV_BITS   = 2 * DIV_STEPS;
	localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;
	typedef logic        [CNT_BITS-1:0]   cnt_t;
	typedef logic        [SLOT_BITS-1:0]  slot_t;

endpackage

`default_nettype wire

// File: rtl/core/swvm_div.sv
// Iterative signed divider by a small count, two quotient bits per cycle.
`default_nettype none

module swvm_div (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  swvm_pkg::sum_t        dividend,
	input  swvm_pkg::cnt_t        divisor,
	output logic                  done,
	output swvm_pkg::coord_t      quotient
);

	logic                                  busy_q;
	logic                                  done_q;
	logic [swvm_pkg::STEP_BITS-1:0]        step_q;
	logic [swvm_pkg::DIV_BITS-1:0]         mag_q;
	logic [swvm_pkg::DIV_BITS-1:0]         quo_q;
	logic [swvm_pkg::SLOT_BITS-1:0]        rem_q;
	swvm_pkg::cnt_t                        den_q;
	logic                                  neg_q;

	logic [swvm_pkg::SLOT_BITS:0]          r1_full;
	logic [swvm_pkg::SLOT_BITS:0]          r2_full;
	logic [swvm_pkg::SLOT_BITS-1:0]        r1;
	logic [swvm_pkg::SLOT_BITS-1:0]        r2;
	logic                                  qb1;
	logic                                  qb2;
	logic [swvm_pkg::DIV_BITS-1:0]         quo_signed;
	swvm_pkg::sum_t                        abs_in;

	// Two restoring steps on the narrow remainder
	always_comb begin
		r1_full = {rem_q, mag_q[swvm_pkg::DIV_BITS-1]};
		qb1     = (r1_full >= den_q);
		r1      = qb1 ? swvm_pkg::SLOT_BITS'(r1_full - den_q) : r1_full[swvm_pkg::SLOT_BITS-1:0];
		r2_full = {r1, mag_q[swvm_pkg::DIV_BITS-2]};
		qb2     = (r2_full >= den_q);
		r2      = qb2 ? swvm_pkg::SLOT_BITS'(r2_full - den_q) : r2_full[swvm_pkg::SLOT_BITS-1:0];
	end

	// Magnitude of the signed dividend
	assign abs_in = dividend[swvm_pkg::SUM_BITS-1] ? -dividend : dividend;

	// Sequencing of the shared step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == swvm_pkg::STEP_BITS'(swvm_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= swvm_pkg::DIV_BITS'(abs_in);
			quo_q <= '0;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[swvm_pkg::SUM_BITS-1];
		end else if (busy_q) begin
			mag_q <= {mag_q[swvm_pkg::DIV_BITS-3:0], 2'b00};
			quo_q <= {quo_q[swvm_pkg::DIV_BITS-3:0], qb1, qb2};
			rem_q <= r2;
		end
	end

	// Truncation toward zero: divide magnitudes, then restore the sign
	assign quo_signed = neg_q ? -quo_q : quo_q;
	assign quotient   = quo_signed[swvm_pkg::COORD_BITS-1:0];
	assign done       = done_q;

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_vector_mean_top.sv
// Sliding-window mean over 3-D Q16.16 samples: ring, running sums, shared divider.
// Per item: drop the oldest samples one at a time (ring read, then subtract), push
//   the new sample, run the three per-axis divisions through the one divider, which
//   dominate the time from accept to result valid, then load the output register.
// Throughput: one item at a time; the next item is taken once the result is in
//   the output register.
// Reset: sums, count, oldest slot cleared, window size 16; ring left unset.
`default_nettype none

module sliding_window_vector_mean_top (
	input  wire          clk,
	input  wire          arst_n,
	// sample_x [31:0], sample_y [63:32], sample_z [95:64]
	input  wire  [95:0]  s_axis_tdata,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// mean_x [31:0], mean_y [63:32], mean_z [95:64], samples_held [100:96], zero pad
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	input  wire          cfg_we,
	input  wire  [4:0]   cfg_wdata
);

	localparam int RING_W = swvm_pkg::AXES * swvm_pkg::COORD_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DROP = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_SUB  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DIVW = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]                state_q;
	swvm_pkg::cnt_t            ws_q;
	swvm_pkg::cnt_t            pmin_q;
	swvm_pkg::cnt_t            limit_q;
	swvm_pkg::cnt_t            held_q;
	swvm_pkg::slot_t           oldest_q;
	swvm_pkg::sum_t            sum_q [swvm_pkg::AXES];
	swvm_pkg::coord_t          res_q [swvm_pkg::AXES];
	logic [1:0]                ax_q;
	logic [RING_W-1:0]         smp_q;
	logic [103:0]              out_data_q;
	logic                      out_valid_q;

	logic [RING_W-1:0]         ring_mem [swvm_pkg::WINDOW_MAX];
	logic [RING_W-1:0]         ring_rd_q;
	logic                      ring_we;
	swvm_pkg::slot_t           wr_slot;

	swvm_pkg::cnt_t            cfg_clamped;
	swvm_pkg::cnt_t            ws_m1;
	swvm_pkg::cnt_t            limit_in;
	logic                      accept;
	logic                      div_start;
	logic                      div_done;
	swvm_pkg::sum_t            div_dividend;
	swvm_pkg::coord_t          div_quot;

	function automatic swvm_pkg::sum_t sext(input logic [swvm_pkg::COORD_BITS-1:0] c);
		return {{swvm_pkg::SLOT_BITS{c[swvm_pkg::COORD_BITS-1]}}, c};
	endfunction

	// Window size register value: zero acts as one, saturate at the ring depth
	always_comb begin
		priority if (cfg_wdata == 5'd0)
			cfg_clamped = swvm_pkg::CNT_BITS'(1);
		else if (swvm_pkg::CNT_BITS'(cfg_wdata) > swvm_pkg::CNT_BITS'(swvm_pkg::WINDOW_MAX))
			cfg_clamped = swvm_pkg::CNT_BITS'(swvm_pkg::WINDOW_MAX);
		else
			cfg_clamped = swvm_pkg::CNT_BITS'(cfg_wdata);
	end

	// Keep at most min(smallest window written since last item, window - 1) before the push
	assign ws_m1    = ws_q - 1'b1;
	assign limit_in = (pmin_q < ws_m1) ? pmin_q : ws_m1;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign ring_we       = (state_q == S_DROP) && !(held_q > limit_q);
	assign wr_slot       = oldest_q + held_q[swvm_pkg::SLOT_BITS-1:0];
	assign div_start     = (state_q == S_DIV);
	assign div_dividend  = sum_q[ax_q];

	// Sample ring, registered read at the oldest slot
	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[wr_slot] <= smp_q;
		ring_rd_q <= ring_mem[oldest_q];
	end

	// Input sample capture
	always_ff @(posedge clk) begin
		if (accept)
			smp_q <= s_axis_tdata;
	end

	// Sequencer, window state and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ws_q     <= swvm_pkg::CNT_BITS'(swvm_pkg::WINDOW_MAX);
			pmin_q   <= swvm_pkg::CNT_BITS'(swvm_pkg::WINDOW_MAX);
			limit_q  <= '0;
			held_q   <= '0;
			oldest_q <= '0;
			ax_q     <= '0;
			for (int a = 0; a < swvm_pkg::AXES; a++)
				sum_q[a] <= '0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_clamped;
				if (cfg_clamped < pmin_q)
					pmin_q <= cfg_clamped;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						limit_q <= limit_in;
						pmin_q  <= swvm_pkg::CNT_BITS'(swvm_pkg::WINDOW_MAX);
						state_q <= S_DROP;
					end
				end
				S_DROP: begin
					if (held_q > limit_q) begin
						state_q <= S_RD;
					end else begin
						// push the new sample
						for (int a = 0; a < swvm_pkg::AXES; a++)
							sum_q[a] <= sum_q[a] +
								sext(smp_q[a*swvm_pkg::COORD_BITS +: swvm_pkg::COORD_BITS]);
						held_q  <= held_q + 1'b1;
						ax_q    <= '0;
						state_q <= S_DIV;
					end
				end
				S_RD: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					// drop the oldest sample
					for (int a = 0; a < swvm_pkg::AXES; a++)
						sum_q[a] <= sum_q[a] -
							sext(ring_rd_q[a*swvm_pkg::COORD_BITS +: swvm_pkg::COORD_BITS]);
					oldest_q <= oldest_q + 1'b1;
					held_q   <= held_q - 1'b1;
					state_q  <= S_DROP;
				end
				S_DIV: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						if (ax_q == 2'(swvm_pkg::AXES - 1)) begin
							state_q <= S_OUT;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || m_axis_tready)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-axis quotients
	always_ff @(posedge clk) begin
		if (state_q == S_DIVW && div_done)
			res_q[ax_q] <= div_quot;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || m_axis_tready))
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || m_axis_tready))
			out_data_q <= {3'b000, held_q, res_q[2], res_q[1], res_q[0]};
	end

	assign m_axis_tdata  = out_data_q;
	assign m_axis_tvalid = out_valid_q;

	swvm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (held_q),
		.done     (div_done),
		.quotient (div_quot)
	);

`ifndef NO_ASSERTIONS
	// Count never exceeds the ring depth
	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= swvm_pkg::CNT_BITS'(swvm_pkg::WINDOW_MAX))
		else $error("held count above ring depth");

	// A push only lands with room left in the window
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ring_we |-> (held_q < ws_q))
		else $error("push into a full window");

	// One item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second item accepted while busy");

	// A delivered result always reports a nonzero count within range
	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[100:96] != 5'd0 &&
			m_axis_tdata[100:96] <= 5'(swvm_pkg::WINDOW_MAX)))
		else $error("result count out of range");
`endif

endmodule

`default_nettype wire
